/* rtl/tds_pkg.sv */
// shared types and constants of the touch digitizer sample source
// calibration register set, request and register codes, datapath widths
// no dependencies
`default_nettype none

package tds_pkg;

	localparam int ADC_BITS    = 12;
	localparam int BURST_WORDS = 8;
	localparam int BURST_IDX_W = $clog2(BURST_WORDS);
	localparam int RAW_FIELD_W = 12;
	localparam int STEP_W      = $clog2(ADC_BITS + 1);

	localparam logic [ADC_BITS-1:0] RAW_MAX = {ADC_BITS{1'b1}};

	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	// datapath widths
	localparam int MA_W   = 37;
	localparam int MB_W   = 16;
	localparam int PROD_W = MA_W + MB_W;
	localparam int DET_W  = 33;
	localparam int DMAG_W = 32;
	localparam int BX_W   = 37;
	localparam int NUM_W  = 54;
	localparam int MAG_W  = NUM_W - 1;
	localparam int DSH_W  = DMAG_W + ADC_BITS;

	localparam logic [15:0] PEN_BIT = 16'h8000;
	localparam logic [15:0] SEL_X   = 16'h1000;
	localparam logic [15:0] SEL_Y   = 16'h2000;

	localparam logic [1:0] REQ_DOWN = 2'd0;
	localparam logic [1:0] REQ_MOVE = 2'd1;
	localparam logic [1:0] REQ_UP   = 2'd2;
	localparam logic [1:0] REQ_TICK = 2'd3;

	localparam logic RESULT_BURST  = 1'b0;
	localparam logic RESULT_PEN_UP = 1'b1;

	localparam logic [2:0] REG_CAL_XX       = 3'd0;
	localparam logic [2:0] REG_CAL_XY       = 3'd1;
	localparam logic [2:0] REG_CAL_X_OFFSET = 3'd2;
	localparam logic [2:0] REG_CAL_YX       = 3'd3;
	localparam logic [2:0] REG_CAL_YY       = 3'd4;
	localparam logic [2:0] REG_CAL_Y_OFFSET = 3'd5;
	localparam logic [2:0] REG_CAL_DIVISOR  = 3'd6;

	localparam logic [15:0] CAL_XX_RST       = 16'(556);
	localparam logic [15:0] CAL_XY_RST       = 16'(-23408);
	localparam logic [31:0] CAL_X_OFFSET_RST = 32'(85992351);
	localparam logic [15:0] CAL_YX_RST       = 16'(-30734);
	localparam logic [15:0] CAL_YY_RST       = 16'(109);
	localparam logic [31:0] CAL_Y_OFFSET_RST = 32'(113344548);
	localparam logic [23:0] CAL_DIVISOR_RST  = 24'(331292);

	typedef struct packed {
		logic [15:0] xx;
		logic [15:0] xy;
		logic [31:0] x_offset;
		logic [15:0] yx;
		logic [15:0] yy;
		logic [31:0] y_offset;
		logic [23:0] divisor;
	} cal_t;

endpackage

`default_nettype wire

/* rtl/touch_digitizer_sample_source_core.sv */
// touch digitizer sample source, top level
// pen state, calibration registers, burst sequencer and output register
// depends on tds_pkg and tds_calc
//
// requests enter on in_valid/in_stall: pen down, pen move, pen up, sample tick.
// a pen-down while up, and a tick while down, give a burst of 8 codec words
// alternating x and y; a pen-up while down gives one pen-up notice.
// requests that give no result are taken without raising in_stall.
// a burst request holds in_stall high while the raw values are computed (products
// on one shared multiplier, then per coordinate a setup step and compare-subtract
// steps on one shared subtractor, then a registered done handoff) and while the
// words leave one per cycle through the output register, as long as out_stall
// is low; the next request is taken once the last word is in that register.
// a pen-up notice also passes through the emit state into the output register,
// and in_stall stays high until it is loaded there.
// when the receiver raises out_stall the output register holds its word and
// the sequencer waits. calibration registers sit on the apb port, 4 bytes apart.
// reset puts the pen up at position zero and loads the default calibration.
`default_nettype none

module touch_digitizer_sample_source_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [tds_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [tds_pkg::DATA_W-1:0]   pwdata,
	output logic      [tds_pkg::DATA_W-1:0]   prdata,
	output logic                              pready,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [1:0]                   req_type,
	input  wire logic [11:0]                  screen_x,
	input  wire logic [11:0]                  screen_y,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic                              result_kind,
	output logic [15:0]                       codec_word,
	output logic                              pen_state,
	output logic                              last_word
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CALC = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	tds_pkg::cal_t cal_q;
	logic [2:0]    reg_idx;
	logic          cfg_wr;

	logic [1:0]  state_q;
	logic        pen_down_q;
	logic [11:0] pen_x_q;
	logic [11:0] pen_y_q;
	logic        emit_kind_q;
	logic [tds_pkg::BURST_IDX_W-1:0] emit_idx_q;

	logic        out_valid_q;
	logic        result_kind_q;
	logic [15:0] codec_word_q;
	logic        pen_state_q;
	logic        last_word_q;

	logic        in_take;
	logic        calc_start;
	logic        calc_done;
	logic [tds_pkg::ADC_BITS-1:0] raw_x;
	logic [tds_pkg::ADC_BITS-1:0] raw_y;

	logic        out_load;
	logic        emit_last;
	logic [15:0] emit_word;

	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q.xx       <= tds_pkg::CAL_XX_RST;
			cal_q.xy       <= tds_pkg::CAL_XY_RST;
			cal_q.x_offset <= tds_pkg::CAL_X_OFFSET_RST;
			cal_q.yx       <= tds_pkg::CAL_YX_RST;
			cal_q.yy       <= tds_pkg::CAL_YY_RST;
			cal_q.y_offset <= tds_pkg::CAL_Y_OFFSET_RST;
			cal_q.divisor  <= tds_pkg::CAL_DIVISOR_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				tds_pkg::REG_CAL_XX:       cal_q.xx       <= pwdata[15:0];
				tds_pkg::REG_CAL_XY:       cal_q.xy       <= pwdata[15:0];
				tds_pkg::REG_CAL_X_OFFSET: cal_q.x_offset <= pwdata[31:0];
				tds_pkg::REG_CAL_YX:       cal_q.yx       <= pwdata[15:0];
				tds_pkg::REG_CAL_YY:       cal_q.yy       <= pwdata[15:0];
				tds_pkg::REG_CAL_Y_OFFSET: cal_q.y_offset <= pwdata[31:0];
				tds_pkg::REG_CAL_DIVISOR:  cal_q.divisor  <= pwdata[23:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			tds_pkg::REG_CAL_XX:       prdata = tds_pkg::DATA_W'(cal_q.xx);
			tds_pkg::REG_CAL_XY:       prdata = tds_pkg::DATA_W'(cal_q.xy);
			tds_pkg::REG_CAL_X_OFFSET: prdata = cal_q.x_offset;
			tds_pkg::REG_CAL_YX:       prdata = tds_pkg::DATA_W'(cal_q.yx);
			tds_pkg::REG_CAL_YY:       prdata = tds_pkg::DATA_W'(cal_q.yy);
			tds_pkg::REG_CAL_Y_OFFSET: prdata = cal_q.y_offset;
			tds_pkg::REG_CAL_DIVISOR:  prdata = tds_pkg::DATA_W'(cal_q.divisor);
			default:                   prdata = '0;
		endcase
	end

	assign in_stall = (state_q != ST_IDLE);
	assign in_take  = in_valid && !in_stall;

	assign calc_start = in_take
		&& ((req_type == tds_pkg::REQ_DOWN && !pen_down_q)
		|| (req_type == tds_pkg::REQ_TICK && pen_down_q));

	tds_calc u_calc (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (calc_start),
		.cal    (cal_q),
		.pen_x  (pen_x_q),
		.pen_y  (pen_y_q),
		.done   (calc_done),
		.raw_x  (raw_x),
		.raw_y  (raw_y)
	);

	assign out_load  = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);
	assign emit_last = (emit_kind_q == tds_pkg::RESULT_PEN_UP)
		|| (emit_idx_q == tds_pkg::BURST_IDX_W'(tds_pkg::BURST_WORDS - 1));
	assign emit_word = emit_idx_q[0]
		? (tds_pkg::PEN_BIT | tds_pkg::SEL_Y
			| 16'(tds_pkg::RAW_FIELD_W'(raw_y)))
		: (tds_pkg::PEN_BIT | tds_pkg::SEL_X
			| 16'(tds_pkg::RAW_FIELD_W'(raw_x)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pen_down_q  <= 1'b0;
			pen_x_q     <= '0;
			pen_y_q     <= '0;
			emit_kind_q <= tds_pkg::RESULT_BURST;
			emit_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						case (req_type)
							tds_pkg::REQ_DOWN: begin
								pen_x_q <= screen_x;
								pen_y_q <= screen_y;
								if (!pen_down_q) begin
									pen_down_q <= 1'b1;
									state_q    <= ST_CALC;
								end
							end
							tds_pkg::REQ_MOVE: begin
								pen_x_q <= screen_x;
								pen_y_q <= screen_y;
							end
							tds_pkg::REQ_UP: begin
								if (pen_down_q) begin
									pen_down_q  <= 1'b0;
									emit_kind_q <= tds_pkg::RESULT_PEN_UP;
									emit_idx_q  <= '0;
									state_q     <= ST_EMIT;
								end
							end
							default: begin
								if (pen_down_q) begin
									state_q <= ST_CALC;
								end
							end
						endcase
					end
				end
				ST_CALC: begin
					if (calc_done) begin
						emit_kind_q <= tds_pkg::RESULT_BURST;
						emit_idx_q  <= '0;
						state_q     <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_load) begin
						if (emit_last) begin
							state_q <= ST_IDLE;
						end else begin
							emit_idx_q <= emit_idx_q + tds_pkg::BURST_IDX_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			result_kind_q <= emit_kind_q;
			last_word_q   <= emit_last;
			if (emit_kind_q == tds_pkg::RESULT_PEN_UP) begin
				codec_word_q <= '0;
				pen_state_q  <= 1'b0;
			end else begin
				codec_word_q <= emit_word;
				pen_state_q  <= 1'b1;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign result_kind = result_kind_q;
	assign codec_word  = codec_word_q;
	assign pen_state   = pen_state_q;
	assign last_word   = last_word_q;

endmodule

`default_nettype wire

/* rtl/tds_calc.sv */
// raw value calculator: inverse affine calibration with clamp
// one shared multiplier for products, one shared subtractor for restoring division
// depends on tds_pkg
`default_nettype none

module tds_calc (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire tds_pkg::cal_t                 cal,
	input  wire logic [11:0]                   pen_x,
	input  wire logic [11:0]                   pen_y,
	output logic                               done,
	output logic [tds_pkg::ADC_BITS-1:0]       raw_x,
	output logic [tds_pkg::ADC_BITS-1:0]       raw_y
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_DSET = 2'd2;
	localparam logic [1:0] ST_DIV  = 2'd3;

	localparam logic [3:0] MUL_LAST = 4'd8;

	logic [1:0] state_q;
	logic [3:0] cyc_q;
	logic       sel_q;
	logic       done_q;

	logic signed [tds_pkg::MA_W-1:0]   mul_a;
	logic signed [tds_pkg::MB_W-1:0]   mul_b;
	logic signed [tds_pkg::PROD_W-1:0] mul_p;

	logic [tds_pkg::PROD_W-1:0] prod_q;
	logic [tds_pkg::NUM_W-1:0]  prod_ext;
	logic [2:0]                 acc_tag;
	logic [tds_pkg::DET_W-1:0]  det_q;
	logic [tds_pkg::BX_W-1:0]   bx_q;
	logic [tds_pkg::BX_W-1:0]   by_q;
	logic [tds_pkg::NUM_W-1:0]  nx_q;
	logic [tds_pkg::NUM_W-1:0]  ny_q;

	logic [tds_pkg::MAG_W-1:0]    rem_q;
	logic [tds_pkg::DSH_W-1:0]    dsh_q;
	logic [tds_pkg::STEP_W-1:0]   j_q;
	logic [tds_pkg::ADC_BITS-1:0] q_q;
	logic [tds_pkg::ADC_BITS-1:0] rx_q;
	logic [tds_pkg::ADC_BITS-1:0] ry_q;

	logic [tds_pkg::NUM_W-1:0]    num_sel;
	logic [tds_pkg::NUM_W-1:0]    num_neg;
	logic [tds_pkg::MAG_W-1:0]    nmag;
	logic [tds_pkg::DET_W-1:0]    det_neg;
	logic [tds_pkg::DMAG_W-1:0]   dmag;
	logic                         skip;
	logic [tds_pkg::MAG_W:0]      diff;
	logic                         ge;
	logic [tds_pkg::ADC_BITS-1:0] q_next;
	logic                         fin;
	logic [tds_pkg::ADC_BITS-1:0] fin_val;

	always_comb begin
		case (cyc_q[2:0])
			3'd0: begin
				mul_a = {{(tds_pkg::MA_W-16){cal.xx[15]}}, cal.xx};
				mul_b = cal.yy;
			end
			3'd1: begin
				mul_a = {{(tds_pkg::MA_W-16){cal.xy[15]}}, cal.xy};
				mul_b = cal.yx;
			end
			3'd2: begin
				mul_a = {{(tds_pkg::MA_W-24){1'b0}}, cal.divisor};
				mul_b = {{(tds_pkg::MB_W-12){pen_x[11]}}, pen_x};
			end
			3'd3: begin
				mul_a = {{(tds_pkg::MA_W-24){1'b0}}, cal.divisor};
				mul_b = {{(tds_pkg::MB_W-12){pen_y[11]}}, pen_y};
			end
			3'd4: begin
				mul_a = bx_q;
				mul_b = cal.yy;
			end
			3'd5: begin
				mul_a = by_q;
				mul_b = cal.xy;
			end
			3'd6: begin
				mul_a = by_q;
				mul_b = cal.xx;
			end
			default: begin
				mul_a = bx_q;
				mul_b = cal.yx;
			end
		endcase
	end

	assign mul_p    = mul_a * mul_b;
	assign prod_ext = {prod_q[tds_pkg::PROD_W-1], prod_q};
	assign acc_tag  = 3'(cyc_q - 4'd1);

	// operand magnitudes and sign tests for the division
	assign num_sel = sel_q ? ny_q : nx_q;
	assign num_neg = tds_pkg::NUM_W'(0) - num_sel;
	assign nmag    = num_sel[tds_pkg::NUM_W-1] ? num_neg[tds_pkg::MAG_W-1:0]
		: num_sel[tds_pkg::MAG_W-1:0];
	assign det_neg = tds_pkg::DET_W'(0) - det_q;
	assign dmag    = det_q[tds_pkg::DET_W-1] ? det_neg[tds_pkg::DMAG_W-1:0]
		: det_q[tds_pkg::DMAG_W-1:0];
	assign skip    = (det_q == '0) || (num_sel == '0)
		|| (num_sel[tds_pkg::NUM_W-1] != det_q[tds_pkg::DET_W-1]);

	assign diff   = {1'b0, rem_q} - (tds_pkg::MAG_W+1)'(dsh_q);
	assign ge     = !diff[tds_pkg::MAG_W];
	assign q_next = {q_q[tds_pkg::ADC_BITS-2:0], ge};

	always_comb begin
		fin     = 1'b0;
		fin_val = '0;
		case (state_q)
			ST_DSET: begin
				fin     = skip;
				fin_val = '0;
			end
			ST_DIV: begin
				if (j_q == tds_pkg::STEP_W'(tds_pkg::ADC_BITS) && ge) begin
					fin     = 1'b1;
					fin_val = tds_pkg::RAW_MAX;
				end else if (j_q == '0) begin
					fin     = 1'b1;
					fin_val = q_next;
				end
			end
			default: begin
				fin     = 1'b0;
				fin_val = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cyc_q   <= '0;
			sel_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= fin && sel_q;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_MUL;
						cyc_q   <= '0;
					end
				end
				ST_MUL: begin
					if (cyc_q == MUL_LAST) begin
						state_q <= ST_DSET;
						sel_q   <= 1'b0;
					end else begin
						cyc_q <= cyc_q + 4'd1;
					end
				end
				ST_DSET, ST_DIV: begin
					if (fin) begin
						sel_q   <= 1'b1;
						state_q <= sel_q ? ST_IDLE : ST_DSET;
					end else if (state_q == ST_DSET) begin
						state_q <= ST_DIV;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			prod_q <= mul_p;
			if (cyc_q != '0) begin
				case (acc_tag)
					3'd0: det_q <= prod_q[tds_pkg::DET_W-1:0];
					3'd1: det_q <= det_q - prod_q[tds_pkg::DET_W-1:0];
					3'd2: bx_q <= prod_q[tds_pkg::BX_W-1:0]
						- {{(tds_pkg::BX_W-32){cal.x_offset[31]}}, cal.x_offset};
					3'd3: by_q <= prod_q[tds_pkg::BX_W-1:0]
						- {{(tds_pkg::BX_W-32){cal.y_offset[31]}}, cal.y_offset};
					3'd4: nx_q <= prod_ext;
					3'd5: nx_q <= nx_q - prod_ext;
					3'd6: ny_q <= prod_ext;
					default: ny_q <= ny_q - prod_ext;
				endcase
			end
		end
		if (state_q == ST_DSET) begin
			rem_q <= nmag;
			dsh_q <= {dmag, {tds_pkg::ADC_BITS{1'b0}}};
			j_q   <= tds_pkg::STEP_W'(tds_pkg::ADC_BITS);
			q_q   <= '0;
		end
		if (state_q == ST_DIV) begin
			if (ge) begin
				rem_q <= diff[tds_pkg::MAG_W-1:0];
			end
			dsh_q <= dsh_q >> 1;
			j_q   <= j_q - tds_pkg::STEP_W'(1);
			q_q   <= q_next;
		end
		if (fin) begin
			if (!sel_q) begin
				rx_q <= fin_val;
			end else begin
				ry_q <= fin_val;
			end
		end
	end

	assign done  = done_q;
	assign raw_x = rx_q;
	assign raw_y = ry_q;

endmodule

`default_nettype wire
